/* src/first_fit_range_allocator_assert.svh */
// Assertion macros used by the allocator's checker.
`ifndef FIRST_FIT_RANGE_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_RANGE_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define FFRA_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock edge.
`define FFRA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* src/ffra_pkg.sv */
// Types, constants and codes of the first-fit range allocator.
package ffra_pkg;

   localparam int POOL_SLOTS  = 65536;
   localparam int TABLE_DEPTH = 64;

   localparam int START_W = 16;
   localparam int SIZE_W  = 17;
   localparam int IDX_W   = $clog2(TABLE_DEPTH);
   localparam int CNT_W   = $clog2(TABLE_DEPTH + 1);
   localparam int OPD_W   = SIZE_W + 1;
   localparam int ALU_W   = OPD_W + 1;

   localparam logic [SIZE_W-1:0] SIZE_MAX   = '1;
   localparam logic [ALU_W-1:0]  POOL_LIMIT = ALU_W'(POOL_SLOTS);
   localparam logic [CNT_W-1:0]  TABLE_FULL = CNT_W'(TABLE_DEPTH);

   localparam logic FUNC_ALLOC   = 1'b0;
   localparam logic FUNC_RELEASE = 1'b1;

   localparam logic [1:0] STATUS_DONE      = 2'd0;
   localparam logic [1:0] STATUS_ZERO      = 2'd1;
   localparam logic [1:0] STATUS_EXHAUSTED = 2'd2;
   localparam logic [1:0] STATUS_FULL      = 2'd3;

   typedef struct packed {
      logic [START_W-1:0] start;
      logic [SIZE_W-1:0]  size;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef enum logic {
      ALU_ADD,
      ALU_SUB
   } alu_op_type;

   typedef struct packed {
      alu_op_type       op;
      logic [OPD_W-1:0] a;
      logic [OPD_W-1:0] b;
   } alu_req_type;

   typedef struct packed {
      logic [ALU_W-1:0]  res;
      logic              borrow;
      logic              zero;
      logic [SIZE_W-1:0] sat;
   } alu_rsp_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_ASCAN,
      S_ATRIM,
      S_AHW,
      S_RSCAN,
      S_RMP,
      S_RMN,
      S_RDEC,
      S_RMERGE1,
      S_RMERGE2,
      S_SHDN,
      S_SHUP
   } state_type;

endpackage

/* src/ffra_ram.sv */
// Single-write, single-read memory with a registered read port.
module ffra_ram #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 33
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

/* src/ffra_alu.sv */
// Shared adder-subtractor with borrow, zero and 17-bit saturation outputs.
module ffra_alu (
   input  ffra_pkg::alu_req_type req,
   output ffra_pkg::alu_rsp_type rsp
);
   import ffra_pkg::*;

   logic [ALU_W-1:0] sum;

   always_comb begin
      if (req.op == ALU_SUB) begin
         sum = {1'b0, req.a} - {1'b0, req.b};
      end else begin
         sum = {1'b0, req.a} + {1'b0, req.b};
      end
   end

   // For a subtraction the top bit is the borrow, so it flags a < b.
   assign rsp.res    = sum;
   assign rsp.borrow = sum[ALU_W-1];
   assign rsp.zero   = (sum == '0);
   assign rsp.sat    = (sum[ALU_W-1:SIZE_W] != '0) ? SIZE_MAX : sum[SIZE_W-1:0];

endmodule

/* src/first_fit_range_allocator.sv */
// Top level: sequencer and datapath of the first-fit range allocator.
//
//   Channel | Ports                                              | Beat taken when
//   --------+----------------------------------------------------+-------------------------
//   request | start, busy, req_func, req_run_base, req_run_length | start high and busy low
//   result  | rsp_valid, rsp_granted_base, rsp_status            | the cycle rsp_valid is high
//
// A zero-length request answers in the next cycle without going busy. Any other
// request walks the sorted free table one entry per cycle through the single read
// port of the table memory and then shifts entries one per cycle on an insert or
// erase. The result strobe rises in the same cycle in which busy falls.
// Synchronous reset empties the table and clears the high-water pointer at once.
// The result is a one-cycle strobe; the receiver cannot stall it.
module first_fit_range_allocator (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic                         req_func,
   input  logic [ffra_pkg::START_W-1:0] req_run_base,
   input  logic [ffra_pkg::SIZE_W-1:0]  req_run_length,
   output logic                         rsp_valid,
   output logic [ffra_pkg::START_W-1:0] rsp_granted_base,
   output logic [1:0]                   rsp_status
);
   import ffra_pkg::*;

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [SIZE_W-1:0]  hw_ff, hw_in;
   logic               pend_ff, pend_in;
   logic               rsp_valid_ff, rsp_valid_in;

   logic [START_W-1:0] base_ff, base_in;
   logic [SIZE_W-1:0]  len_ff, len_in;
   logic [CNT_W-1:0]   idx_ff, idx_in;
   logic [CNT_W-1:0]   pos_ff, pos_in;
   entry_type          prev_ff, prev_in;
   entry_type          next_ff, next_in;
   logic               have_prev_ff, have_prev_in;
   logic               have_next_ff, have_next_in;
   logic               mp_ff, mp_in;
   logic               mn_ff, mn_in;
   logic [SIZE_W-1:0]  acc_ff, acc_in;
   logic [START_W-1:0] grant_ff, grant_in;
   logic [START_W-1:0] rsp_base_ff, rsp_base_in;
   logic [1:0]         rsp_status_ff, rsp_status_in;

   logic               ram_wr_en;
   logic [IDX_W-1:0]   ram_wr_addr;
   entry_type          ram_wr_entry;
   logic               ram_rd_en;
   logic [IDX_W-1:0]   ram_rd_addr;
   logic [ENTRY_W-1:0] ram_rd_data;
   entry_type          rd_entry;

   alu_req_type        alu_req;
   alu_rsp_type        alu_rsp;

   logic               accept;
   logic               scan_hit;
   logic               scan_more;
   logic               up_more;
   logic               table_full;
   logic [CNT_W-1:0]   idx_inc;
   logic [CNT_W-1:0]   idx_dec;
   logic [CNT_W-1:0]   idx_sub2;
   logic [CNT_W-1:0]   idx_add1;
   logic [CNT_W-1:0]   pos_dec;
   logic [CNT_W-1:0]   pos_inc;

   ffra_ram #(
      .DEPTH(TABLE_DEPTH),
      .WIDTH(ENTRY_W)
   ) u_table (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data(ram_wr_entry),
      .rd_en  (ram_rd_en),
      .rd_addr(ram_rd_addr),
      .rd_data(ram_rd_data)
   );

   ffra_alu u_alu (
      .req(alu_req),
      .rsp(alu_rsp)
   );

   assign rd_entry   = entry_type'(ram_rd_data);
   assign accept     = start && (state_ff == S_IDLE);
   assign scan_hit   = pend_ff && !alu_rsp.borrow;
   assign scan_more  = (idx_ff < count_ff);
   assign up_more    = (idx_ff > pos_ff);
   assign table_full = (count_ff == TABLE_FULL);
   assign idx_inc    = idx_ff + CNT_W'(1);
   assign idx_dec    = idx_ff - CNT_W'(1);
   assign idx_sub2   = idx_ff - CNT_W'(2);
   assign idx_add1   = idx_ff + CNT_W'(1);
   assign pos_dec    = pos_ff - CNT_W'(1);
   assign pos_inc    = pos_ff + CNT_W'(1);

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept && (req_run_length != '0)) begin
               state_in = (req_func == FUNC_ALLOC) ? S_ASCAN : S_RSCAN;
            end
         end
         S_ASCAN: begin
            if (scan_hit) begin
               state_in = alu_rsp.zero ? S_SHDN : S_ATRIM;
            end else if (!scan_more) begin
               state_in = S_AHW;
            end
         end
         S_ATRIM:   state_in = S_IDLE;
         S_AHW:     state_in = S_IDLE;
         S_RSCAN: begin
            if (scan_hit || !scan_more) begin
               state_in = S_RMP;
            end
         end
         S_RMP:     state_in = S_RMN;
         S_RMN:     state_in = S_RDEC;
         S_RDEC: begin
            if (mp_ff || mn_ff) begin
               state_in = S_RMERGE1;
            end else if (table_full) begin
               state_in = S_IDLE;
            end else begin
               state_in = S_SHUP;
            end
         end
         S_RMERGE1: state_in = (mp_ff && mn_ff) ? S_RMERGE2 : S_IDLE;
         S_RMERGE2: state_in = S_SHDN;
         S_SHDN: begin
            if (!scan_more) begin
               state_in = S_IDLE;
            end
         end
         S_SHUP: begin
            if (!up_more && !pend_ff) begin
               state_in = S_IDLE;
            end
         end
         default:   state_in = S_IDLE;
      endcase
   end

   // Datapath, memory and shared-unit control.
   always_comb begin
      count_in      = count_ff;
      hw_in         = hw_ff;
      pend_in       = pend_ff;
      rsp_valid_in  = 1'b0;
      base_in       = base_ff;
      len_in        = len_ff;
      idx_in        = idx_ff;
      pos_in        = pos_ff;
      prev_in       = prev_ff;
      next_in       = next_ff;
      have_prev_in  = have_prev_ff;
      have_next_in  = have_next_ff;
      mp_in         = mp_ff;
      mn_in         = mn_ff;
      acc_in        = acc_ff;
      grant_in      = grant_ff;
      rsp_base_in   = rsp_base_ff;
      rsp_status_in = rsp_status_ff;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = '0;
      ram_wr_entry  = '0;
      ram_rd_en     = 1'b0;
      ram_rd_addr   = '0;
      alu_req.op    = ALU_ADD;
      alu_req.a     = '0;
      alu_req.b     = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               base_in      = req_run_base;
               len_in       = req_run_length;
               idx_in       = '0;
               pend_in      = 1'b0;
               have_prev_in = 1'b0;
               have_next_in = 1'b0;
               grant_in     = '0;
               if (req_run_length == '0) begin
                  rsp_valid_in  = 1'b1;
                  rsp_base_in   = '0;
                  rsp_status_in = STATUS_ZERO;
               end
            end
         end
         S_ASCAN: begin
            alu_req.op = ALU_SUB;
            alu_req.a  = OPD_W'(rd_entry.size);
            alu_req.b  = OPD_W'(len_ff);
            if (scan_hit) begin
               grant_in = rd_entry.start;
               acc_in   = alu_rsp.res[SIZE_W-1:0];
               pos_in   = idx_dec;
               pend_in  = 1'b0;
            end else if (scan_more) begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = idx_ff[IDX_W-1:0];
               idx_in      = idx_inc;
               pend_in     = 1'b1;
            end else begin
               pend_in = 1'b0;
            end
         end
         S_ATRIM: begin
            alu_req.a          = OPD_W'(grant_ff);
            alu_req.b          = OPD_W'(len_ff);
            ram_wr_en          = 1'b1;
            ram_wr_addr        = pos_ff[IDX_W-1:0];
            ram_wr_entry.start = alu_rsp.res[START_W-1:0];
            ram_wr_entry.size  = acc_ff;
            rsp_valid_in       = 1'b1;
            rsp_base_in        = grant_ff;
            rsp_status_in      = STATUS_DONE;
         end
         S_AHW: begin
            alu_req.a    = OPD_W'(hw_ff);
            alu_req.b    = OPD_W'(len_ff);
            rsp_valid_in = 1'b1;
            if (alu_rsp.res > POOL_LIMIT) begin
               rsp_base_in   = '0;
               rsp_status_in = STATUS_EXHAUSTED;
            end else begin
               rsp_base_in   = hw_ff[START_W-1:0];
               rsp_status_in = STATUS_DONE;
               hw_in         = alu_rsp.res[SIZE_W-1:0];
            end
         end
         S_RSCAN: begin
            // Look for the first entry that starts at or after the released base.
            alu_req.op = ALU_SUB;
            alu_req.a  = OPD_W'(rd_entry.start);
            alu_req.b  = OPD_W'(base_ff);
            if (scan_hit) begin
               next_in      = rd_entry;
               have_next_in = 1'b1;
               pos_in       = idx_dec;
               pend_in      = 1'b0;
            end else begin
               if (pend_ff) begin
                  prev_in      = rd_entry;
                  have_prev_in = 1'b1;
               end
               if (scan_more) begin
                  ram_rd_en   = 1'b1;
                  ram_rd_addr = idx_ff[IDX_W-1:0];
                  idx_in      = idx_inc;
                  pend_in     = 1'b1;
               end else begin
                  pos_in  = idx_ff;
                  pend_in = 1'b0;
               end
            end
         end
         S_RMP: begin
            alu_req.a = OPD_W'(prev_ff.start);
            alu_req.b = OPD_W'(prev_ff.size);
            mp_in     = have_prev_ff && (alu_rsp.res == ALU_W'(base_ff));
         end
         S_RMN: begin
            alu_req.a = OPD_W'(base_ff);
            alu_req.b = OPD_W'(len_ff);
            mn_in     = have_next_ff && (alu_rsp.res == ALU_W'(next_ff.start));
         end
         S_RDEC: begin
            if (!mp_ff && !mn_ff) begin
               if (table_full) begin
                  rsp_valid_in  = 1'b1;
                  rsp_base_in   = '0;
                  rsp_status_in = STATUS_FULL;
               end else begin
                  idx_in  = count_ff;
                  pend_in = 1'b0;
               end
            end
         end
         S_RMERGE1: begin
            alu_req.a = OPD_W'(mp_ff ? prev_ff.size : next_ff.size);
            alu_req.b = OPD_W'(len_ff);
            if (mp_ff && mn_ff) begin
               acc_in = alu_rsp.sat;
            end else begin
               ram_wr_en     = 1'b1;
               rsp_valid_in  = 1'b1;
               rsp_base_in   = '0;
               rsp_status_in = STATUS_DONE;
               if (mp_ff) begin
                  ram_wr_addr        = pos_dec[IDX_W-1:0];
                  ram_wr_entry.start = prev_ff.start;
               end else begin
                  ram_wr_addr        = pos_ff[IDX_W-1:0];
                  ram_wr_entry.start = base_ff;
               end
               ram_wr_entry.size = alu_rsp.sat;
            end
         end
         S_RMERGE2: begin
            // Both neighbors merge: grow the previous entry, then erase the next one.
            alu_req.a          = OPD_W'(acc_ff);
            alu_req.b          = OPD_W'(next_ff.size);
            ram_wr_en          = 1'b1;
            ram_wr_addr        = pos_dec[IDX_W-1:0];
            ram_wr_entry.start = prev_ff.start;
            ram_wr_entry.size  = alu_rsp.sat;
            idx_in             = pos_inc;
            pend_in            = 1'b0;
         end
         S_SHDN: begin
            // The data in the read register came from idx - 1 and moves to idx - 2.
            if (pend_ff) begin
               ram_wr_en    = 1'b1;
               ram_wr_addr  = idx_sub2[IDX_W-1:0];
               ram_wr_entry = rd_entry;
            end
            if (scan_more) begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = idx_ff[IDX_W-1:0];
               idx_in      = idx_inc;
               pend_in     = 1'b1;
            end else begin
               pend_in       = 1'b0;
               count_in      = count_ff - CNT_W'(1);
               rsp_valid_in  = 1'b1;
               rsp_base_in   = grant_ff;
               rsp_status_in = STATUS_DONE;
            end
         end
         S_SHUP: begin
            // The data in the read register came from idx and moves to idx + 1.
            if (pend_ff) begin
               ram_wr_en    = 1'b1;
               ram_wr_addr  = idx_add1[IDX_W-1:0];
               ram_wr_entry = rd_entry;
            end
            if (up_more) begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = idx_dec[IDX_W-1:0];
               idx_in      = idx_dec;
               pend_in     = 1'b1;
            end else if (pend_ff) begin
               pend_in = 1'b0;
            end else begin
               ram_wr_en          = 1'b1;
               ram_wr_addr        = pos_ff[IDX_W-1:0];
               ram_wr_entry.start = base_ff;
               ram_wr_entry.size  = len_ff;
               count_in           = count_ff + CNT_W'(1);
               rsp_valid_in       = 1'b1;
               rsp_base_in        = '0;
               rsp_status_in      = STATUS_DONE;
            end
         end
         default: begin
            pend_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         hw_ff        <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         hw_ff        <= hw_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      base_ff       <= base_in;
      len_ff        <= len_in;
      idx_ff        <= idx_in;
      pos_ff        <= pos_in;
      prev_ff       <= prev_in;
      next_ff       <= next_in;
      have_prev_ff  <= have_prev_in;
      have_next_ff  <= have_next_in;
      mp_ff         <= mp_in;
      mn_ff         <= mn_in;
      acc_ff        <= acc_in;
      grant_ff      <= grant_in;
      rsp_base_ff   <= rsp_base_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign busy             = (state_ff != S_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_granted_base = rsp_base_ff;
   assign rsp_status       = rsp_status_ff;

endmodule

/* src/ffra_checker.sv */
// Port-level checker of the first-fit range allocator, bound to the top level.
`include "first_fit_range_allocator_assert.svh"

module ffra_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         start,
   input logic                         busy,
   input logic [ffra_pkg::SIZE_W-1:0]  req_run_length,
   input logic                         rsp_valid,
   input logic [ffra_pkg::START_W-1:0] rsp_granted_base,
   input logic [1:0]                   rsp_status
);
   import ffra_pkg::*;

   // A zero-length beat is answered in the very next cycle.
   `FFRA_ASSERT_NEXT(zero_len_answer, clock, reset, start && !busy && (req_run_length == '0), rsp_valid && (rsp_status == STATUS_ZERO), "zero-length request not answered next cycle")

   // Any other beat occupies the sequencer.
   `FFRA_ASSERT_NEXT(work_goes_busy, clock, reset, start && !busy && (req_run_length != '0), busy && !rsp_valid, "nonzero request did not start work")

   // Only a successful allocation carries a base.
   `FFRA_ASSERT_IMPLY(no_base_on_fail, clock, reset, rsp_valid && (rsp_status != STATUS_DONE), rsp_granted_base == '0, "failed request returned a base")

   // A result is only issued once the sequencer has finished.
   `FFRA_ASSERT_IMPLY(result_when_idle, clock, reset, rsp_valid, !busy, "result issued while busy")

endmodule

bind first_fit_range_allocator ffra_checker u_checker (.*);
